### hw/rtl/tre_pkg.sv
`timescale 1ns / 1ps

package tre_pkg;

   localparam int PIX_W              = 32;
   localparam int CNT_W              = 8;
   localparam int HDR_W              = 8;
   localparam int PCNT_W             = 3;
   localparam int COL_W              = 16;
   localparam int SLOTS              = 4;
   localparam int MAX_PACKET_DEFAULT = 128;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 4'd1;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef struct packed {
      logic             is_run;
      logic [CNT_W-1:0] count;
      logic [PIX_W-1:0] pixel;
      logic             last;
   } tre_cmd_type;

   function automatic logic [PIX_W-1:0] pix_mask(input logic [PIX_W-1:0] p,
                                                 input logic has_alpha);
      pix_mask = has_alpha ? p : {8'h00, p[23:0]};
   endfunction

   function automatic tre_cmd_type make_cmd(input logic is_run,
                                            input logic [CNT_W-1:0] count,
                                            input logic [PIX_W-1:0] pixel);
      tre_cmd_type c;
      c.is_run = is_run;
      c.count  = count;
      c.pixel  = pixel;
      c.last   = 1'b0;
      make_cmd = c;
   endfunction

endpackage

### hw/rtl/tre_cmd_queue.sv
`timescale 1ns / 1ps

module tre_cmd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  tre_pkg::tre_cmd_type           push_data,
   input  logic                           pop,
   output tre_pkg::tre_cmd_type           pop_data,
   output logic                           empty,
   output logic [tre_pkg::CMDQ_CNT_W-1:0] count
);
   import tre_pkg::*;

   tre_cmd_type            entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]     wr_ptr_ff;
   logic [CMDQ_AW-1:0]     rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]  count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign do_push  = push && (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign do_pop   = pop && (count_ff != '0);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_AW'(1);
         end
         count_ff <= count_ff + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH)) |-> !push)
      else $error("command pushed into a full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("command popped from an empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("queue count moved without a request");
`endif

endmodule

### hw/rtl/tre_front.sv
`timescale 1ns / 1ps

module tre_front #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEFAULT,
   parameter int RING_AW    = $clog2(2 * MAX_PACKET)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [tre_pkg::PIX_W-1:0]      pixel_word,
   input  logic                           has_alpha,
   input  logic [tre_pkg::COL_W-1:0]      row_width,
   input  logic [tre_pkg::CMDQ_CNT_W-1:0] cmdq_count,
   output logic                           cmd_push,
   output tre_pkg::tre_cmd_type           cmd_data,
   output logic                           wr_en,
   output logic [RING_AW-1:0]             wr_addr,
   output logic [tre_pkg::PIX_W-1:0]      wr_data,
   input  logic                           consume
);
   import tre_pkg::*;

   localparam int RING  = 1 << RING_AW;
   localparam int OCC_W = $clog2(RING + 1);

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   hr_ff, hr_in;
   logic [PIX_W-1:0]   hp_ff, hp_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [RING_AW-1:0] wr_ptr_ff;

   logic               p2_ff;
   logic               p2_ap_ff;
   logic [PIX_W-1:0]   p2_x_ff;
   logic               p2_cmd_v_ff;
   tre_cmd_type        p2_cmd_ff;

   logic               accept;
   logic               same;
   logic               row_end;
   logic               ap0_v;
   logic [PIX_W-1:0]   ap0_d;
   logic               ap1_v;
   logic [1:0]         cv;
   tre_cmd_type        cq [2];
   logic [CNT_W-1:0]   f1;
   logic               c1_v;
   logic               c2_v;
   tre_cmd_type        c2;

   assign full = p2_ff || (cmdq_count > CMDQ_CNT_W'(CMDQ_DEPTH - 2))
                 || (occ_ff > OCC_W'(RING - 2));
   assign accept = push && !full;

   always_comb begin
      same    = (hr_ff != '0) && (((pixel_word ^ hp_ff) & pix_mask('1, has_alpha)) == '0);
      row_end = ({1'b0, col_ff} + 17'd1) >= {1'b0, row_width};
      hp_in   = hp_ff;
      hr_in   = hr_ff;
      fill_in = fill_ff;
      col_in  = row_end ? '0 : col_ff + 16'd1;
      ap0_v   = 1'b0;
      ap0_d   = pixel_word;
      ap1_v   = 1'b0;
      cv      = '0;
      cq[0]   = '0;
      cq[1]   = '0;
      f1      = fill_ff + 8'd1;
      if (hr_ff == '0) begin
         hp_in = pixel_word;
         hr_in = 8'd1;
         if (row_end) begin
            ap0_v   = 1'b1;
            cv[0]   = 1'b1;
            cq[0]   = make_cmd(1'b0, fill_ff + 8'd1, '0);
            fill_in = '0;
            hr_in   = '0;
         end
      end else if (hr_ff == 8'd1) begin
         if (same) begin
            if (fill_ff != '0) begin
               cv[0] = 1'b1;
               cq[0] = make_cmd(1'b0, fill_ff, '0);
            end
            fill_in = '0;
            hr_in   = 8'd2;
            if (row_end) begin
               if (cv[0]) begin
                  cv[1] = 1'b1;
                  cq[1] = make_cmd(1'b1, 8'd2, hp_ff);
               end else begin
                  cv[0] = 1'b1;
                  cq[0] = make_cmd(1'b1, 8'd2, hp_ff);
               end
               hr_in = '0;
            end
         end else begin
            ap0_v = 1'b1;
            ap0_d = hp_ff;
            if (f1 == CNT_W'(MAX_PACKET)) begin
               cv[0] = 1'b1;
               cq[0] = make_cmd(1'b0, f1, '0);
               f1    = '0;
            end
            hp_in   = pixel_word;
            hr_in   = 8'd1;
            fill_in = f1;
            if (row_end) begin
               ap1_v = 1'b1;
               if (cv[0]) begin
                  cv[1] = 1'b1;
                  cq[1] = make_cmd(1'b0, f1 + 8'd1, '0);
               end else begin
                  cv[0] = 1'b1;
                  cq[0] = make_cmd(1'b0, f1 + 8'd1, '0);
               end
               fill_in = '0;
               hr_in   = '0;
            end
         end
      end else begin
         if (same && (hr_ff < CNT_W'(MAX_PACKET))) begin
            hr_in = hr_ff + 8'd1;
            if (row_end) begin
               cv[0] = 1'b1;
               cq[0] = make_cmd(1'b1, hr_ff + 8'd1, hp_ff);
               hr_in = '0;
            end
         end else begin
            cv[0] = 1'b1;
            cq[0] = make_cmd(1'b1, hr_ff, hp_ff);
            hp_in = pixel_word;
            hr_in = 8'd1;
            if (row_end) begin
               ap0_v = 1'b1;
               cv[1] = 1'b1;
               cq[1] = make_cmd(1'b0, 8'd1, '0);
               hr_in = '0;
            end
         end
      end
      if (cv[1]) begin
         cq[1].last = 1'b1;
      end else if (cv[0]) begin
         cq[0].last = 1'b1;
      end
      // A command that covers the second pixel write waits in the p2 registers and is pushed with that write.
      c1_v = cv[0] && (cv[1] || !ap1_v);
      c2_v = cv[1] || (cv[0] && ap1_v);
      c2   = cv[1] ? cq[1] : cq[0];
   end

   assign wr_en    = (accept && ap0_v) || (p2_ff && p2_ap_ff);
   assign wr_addr  = wr_ptr_ff;
   assign wr_data  = p2_ff ? p2_x_ff : ap0_d;
   assign cmd_push = (accept && c1_v) || (p2_ff && p2_cmd_v_ff);
   assign cmd_data = p2_ff ? p2_cmd_ff : cq[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         hr_ff       <= '0;
         hp_ff       <= '0;
         col_ff      <= '0;
         occ_ff      <= '0;
         wr_ptr_ff   <= '0;
         p2_ff       <= 1'b0;
         p2_ap_ff    <= 1'b0;
         p2_cmd_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff     <= fill_in;
            hr_ff       <= hr_in;
            hp_ff       <= hp_in;
            col_ff      <= col_in;
            p2_ff       <= ap1_v || c2_v;
            p2_ap_ff    <= ap1_v;
            p2_cmd_v_ff <= c2_v;
         end else if (p2_ff) begin
            p2_ff <= 1'b0;
         end
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + RING_AW'(1);
         end
         occ_ff <= occ_ff + OCC_W'(wr_en) - OCC_W'(consume);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p2_x_ff   <= pixel_word;
         p2_cmd_ff <= c2;
      end
   end

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(RING))
      else $error("pixel ring overfilled");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(MAX_PACKET))
      else $error("open raw packet reached its limit");
   a_run_no_raw: assert property (@(posedge clock) disable iff (reset)
      (hr_ff >= 8'd2) |-> (fill_ff == '0))
      else $error("raw pixels pending during a run");
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      hr_ff <= CNT_W'(MAX_PACKET))
      else $error("run longer than a packet");
`endif

endmodule

### hw/rtl/tre_back.sv
`timescale 1ns / 1ps

module tre_back #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEFAULT,
   parameter int RING_AW    = $clog2(2 * MAX_PACKET)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       has_alpha,
   input  logic                       cmd_empty,
   input  tre_pkg::tre_cmd_type       cmd_data,
   output logic                       cmd_pop,
   input  logic                       wr_en,
   input  logic [RING_AW-1:0]         wr_addr,
   input  logic [tre_pkg::PIX_W-1:0]  wr_data,
   output logic                       consume,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_is_header,
   output logic [tre_pkg::HDR_W-1:0]  rsp_header_byte,
   output logic [tre_pkg::PCNT_W-1:0] rsp_pixel_count,
   output logic [tre_pkg::PIX_W-1:0]  rsp_pixel_a,
   output logic [tre_pkg::PIX_W-1:0]  rsp_pixel_b,
   output logic [tre_pkg::PIX_W-1:0]  rsp_pixel_c,
   output logic [tre_pkg::PIX_W-1:0]  rsp_pixel_d,
   output logic                       rsp_end_of_burst
);
   import tre_pkg::*;

   localparam int RING = 1 << RING_AW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_RUN,
      S_READ,
      S_EMIT
   } state_type;

   state_type           state_ff;
   tre_cmd_type         cur_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [PCNT_W-1:0]   take_ff;
   logic [PCNT_W-1:0]   issued_ff;
   logic [PCNT_W-1:0]   got_ff;
   logic [RING_AW-1:0]  rd_ptr_ff;
   logic                rd_v_ff;
   logic [PIX_W-1:0]    rd_data_ff;
   logic [PIX_W-1:0]    slot_ff [SLOTS];
   logic [PIX_W-1:0]    ring_mem [RING];

   logic                out_v_ff;
   logic                out_hdr_ff;
   logic [HDR_W-1:0]    out_byte_ff;
   logic [PCNT_W-1:0]   out_cnt_ff;
   logic [PIX_W-1:0]    out_a_ff;
   logic [PIX_W-1:0]    out_b_ff;
   logic [PIX_W-1:0]    out_c_ff;
   logic [PIX_W-1:0]    out_d_ff;
   logic                out_eob_ff;

   logic                out_free;
   logic                out_load;
   logic                rd_en;
   logic [CNT_W-1:0]    rem_next;

   assign out_free = !out_v_ff || rsp_pop;
   assign out_load = out_free
                     && (state_ff == S_HDR || state_ff == S_RUN || state_ff == S_EMIT);
   assign rd_en    = (state_ff == S_READ) && (issued_ff != take_ff);
   assign consume  = rd_en;
   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty;
   assign rem_next = rem_ff - CNT_W'(take_ff);

   assign rsp_empty        = !out_v_ff;
   assign rsp_is_header    = out_hdr_ff;
   assign rsp_header_byte  = out_byte_ff;
   assign rsp_pixel_count  = out_cnt_ff;
   assign rsp_pixel_a      = out_a_ff;
   assign rsp_pixel_b      = out_b_ff;
   assign rsp_pixel_c      = out_c_ff;
   assign rsp_pixel_d      = out_d_ff;
   assign rsp_end_of_burst = out_eob_ff;

   function automatic logic [PCNT_W-1:0] next_take(input logic [CNT_W-1:0] r);
      next_take = (r >= CNT_W'(SLOTS)) ? PCNT_W'(SLOTS) : r[PCNT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         out_v_ff  <= 1'b0;
         rd_v_ff   <= 1'b0;
         rd_ptr_ff <= '0;
         issued_ff <= '0;
         got_ff    <= '0;
      end else begin
         rd_v_ff <= rd_en;
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + RING_AW'(1);
            issued_ff <= issued_ff + PCNT_W'(1);
         end
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cur_ff   <= cmd_data;
                  state_ff <= S_HDR;
               end
            end
            S_HDR: begin
               if (out_free) begin
                  out_hdr_ff  <= 1'b1;
                  out_byte_ff <= {cur_ff.is_run, 7'(cur_ff.count - 8'd1)};
                  out_cnt_ff  <= '0;
                  out_a_ff    <= '0;
                  out_b_ff    <= '0;
                  out_c_ff    <= '0;
                  out_d_ff    <= '0;
                  out_eob_ff  <= 1'b0;
                  rem_ff      <= cur_ff.count;
                  take_ff     <= next_take(cur_ff.count);
                  issued_ff   <= '0;
                  got_ff      <= '0;
                  state_ff    <= cur_ff.is_run ? S_RUN : S_READ;
               end
            end
            S_RUN: begin
               if (out_free) begin
                  out_hdr_ff  <= 1'b0;
                  out_byte_ff <= '0;
                  out_cnt_ff  <= PCNT_W'(1);
                  out_a_ff    <= pix_mask(cur_ff.pixel, has_alpha);
                  out_b_ff    <= '0;
                  out_c_ff    <= '0;
                  out_d_ff    <= '0;
                  out_eob_ff  <= cur_ff.last;
                  state_ff    <= S_IDLE;
               end
            end
            S_READ: begin
               if (rd_v_ff) begin
                  slot_ff[got_ff[1:0]] <= rd_data_ff;
                  got_ff               <= got_ff + PCNT_W'(1);
                  if ((got_ff + PCNT_W'(1)) == take_ff) begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  out_hdr_ff  <= 1'b0;
                  out_byte_ff <= '0;
                  out_cnt_ff  <= take_ff;
                  out_a_ff    <= pix_mask(slot_ff[0], has_alpha);
                  out_b_ff    <= (take_ff >= 3'd2) ? pix_mask(slot_ff[1], has_alpha) : '0;
                  out_c_ff    <= (take_ff >= 3'd3) ? pix_mask(slot_ff[2], has_alpha) : '0;
                  out_d_ff    <= (take_ff >= 3'd4) ? pix_mask(slot_ff[3], has_alpha) : '0;
                  out_eob_ff  <= cur_ff.last && (rem_next == '0);
                  rem_ff      <= rem_next;
                  take_ff     <= next_take(rem_next);
                  issued_ff   <= '0;
                  got_ff      <= '0;
                  state_ff    <= (rem_next == '0) ? S_IDLE : S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_got_le_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (got_ff <= issued_ff))
      else $error("ring data captured before it was read");
   a_read_in_read: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> (state_ff == S_READ))
      else $error("ring data returned outside the read phase");
   a_take_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_EMIT) |-> (take_ff != '0 && rem_ff != '0))
      else $error("raw packet phase with nothing left to send");
`endif

endmodule

### hw/rtl/tga_rle_packet_encoder.sv
// Path: the command for a pixel that closes a packet passes through the command queue to
// the back end, which registers the header result and then, for a raw packet, reads its pixels from the ring.
// Throughput: one pixel per cycle while the 256-entry pixel ring and the command queue
// have room and the front end is not busy finishing a row end with two pending actions.
// Reset is synchronous: control state clears, has_alpha reads 1 and row_width reads 1;
// the pixel ring is not cleared.
`timescale 1ns / 1ps

module tga_rle_packet_encoder #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [tre_pkg::PIX_W-1:0]      req_pixel_word,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_is_header,
   output logic [tre_pkg::HDR_W-1:0]      rsp_header_byte,
   output logic [tre_pkg::PCNT_W-1:0]     rsp_pixel_count,
   output logic [tre_pkg::PIX_W-1:0]      rsp_pixel_a,
   output logic [tre_pkg::PIX_W-1:0]      rsp_pixel_b,
   output logic [tre_pkg::PIX_W-1:0]      rsp_pixel_c,
   output logic [tre_pkg::PIX_W-1:0]      rsp_pixel_d,
   output logic                           rsp_end_of_burst,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tre_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tre_pkg::*;

   localparam int RING_AW = $clog2(2 * MAX_PACKET);

   logic                  has_alpha_ff;
   logic [COL_W-1:0]      row_width_ff;

   logic                  cmd_push;
   tre_cmd_type           cmd_wdata;
   logic                  cmd_pop;
   tre_cmd_type           cmd_rdata;
   logic                  cmd_empty;
   logic [CMDQ_CNT_W-1:0] cmd_count;
   logic                  wr_en;
   logic [RING_AW-1:0]    wr_addr;
   logic [PIX_W-1:0]      wr_data;
   logic                  consume;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff <= 1'b1;
         row_width_ff <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HAS_ALPHA: has_alpha_ff <= csr_wdata[0];
            CSR_ROW_WIDTH: row_width_ff <= csr_wdata[COL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tre_front #(
      .MAX_PACKET (MAX_PACKET),
      .RING_AW    (RING_AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .pixel_word (req_pixel_word),
      .has_alpha  (has_alpha_ff),
      .row_width  (row_width_ff),
      .cmdq_count (cmd_count),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_wdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .consume    (consume)
   );

   tre_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   tre_back #(
      .MAX_PACKET (MAX_PACKET),
      .RING_AW    (RING_AW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .has_alpha        (has_alpha_ff),
      .cmd_empty        (cmd_empty),
      .cmd_data         (cmd_rdata),
      .cmd_pop          (cmd_pop),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .consume          (consume),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_header    (rsp_is_header),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_pixel_a      (rsp_pixel_a),
      .rsp_pixel_b      (rsp_pixel_b),
      .rsp_pixel_c      (rsp_pixel_c),
      .rsp_pixel_d      (rsp_pixel_d),
      .rsp_end_of_burst (rsp_end_of_burst)
   );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tre_pkg::*;

   localparam int PACKET_MAX    = MAX_PACKET_DEFAULT;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 24;
   localparam int IDLE_PERCENT  = 27;

   typedef struct packed {
      logic                         is_header;
      logic [HDR_W-1:0]             header_byte;
      logic [PCNT_W-1:0]            pixel_count;
      logic [SLOTS-1:0][PIX_W-1:0]  slot;
      logic                         end_of_burst;
   } rle_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [PIX_W-1:0]      req_pixel_word = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_is_header;
   logic [HDR_W-1:0]      rsp_header_byte;
   logic [PCNT_W-1:0]     rsp_pixel_count;
   logic [PIX_W-1:0]      rsp_pixel_a;
   logic [PIX_W-1:0]      rsp_pixel_b;
   logic [PIX_W-1:0]      rsp_pixel_c;
   logic [PIX_W-1:0]      rsp_pixel_d;
   logic                  rsp_end_of_burst;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rle_item_type     packets_due[$];
   logic [PIX_W-1:0] raw_pixels [PACKET_MAX];
   int unsigned      raw_count = 0;
   logic [PIX_W-1:0] cand_pixel = '0;
   int unsigned      cand_len = 0;
   logic [COL_W-1:0] col_pos = '0;
   logic             cfg_alpha = 1'b1;
   logic [COL_W-1:0] cfg_width = COL_W'(1);
   logic [PIX_W-1:0] last_word = '0;
   bit               quiet = 1'b0;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      results_seen = 0;

   tga_rle_packet_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_word   (req_pixel_word),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_header    (rsp_is_header),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_pixel_a      (rsp_pixel_a),
      .rsp_pixel_b      (rsp_pixel_b),
      .rsp_pixel_c      (rsp_pixel_c),
      .rsp_pixel_d      (rsp_pixel_d),
      .rsp_end_of_burst (rsp_end_of_burst),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [PIX_W-1:0] visible(input logic [PIX_W-1:0] p);
      return cfg_alpha ? p : (p & 32'h00FF_FFFF);
   endfunction

   function automatic void queue_item(input logic is_hdr, input logic [HDR_W-1:0] hb,
                                      input logic [PCNT_W-1:0] cnt,
                                      input logic [SLOTS-1:0][PIX_W-1:0] pixels);
      rle_item_type item;
      item.is_header    = is_hdr;
      item.header_byte  = hb;
      item.pixel_count  = cnt;
      for (int k = 0; k < SLOTS; k++)
         item.slot[k] = (k < cnt) ? visible(pixels[k]) : '0;
      item.end_of_burst = 1'b0;
      packets_due.push_back(item);
   endfunction

   function automatic void flush_raw_packet();
      logic [SLOTS-1:0][PIX_W-1:0] group;
      int unsigned n;
      if (raw_count == 0)
         return;
      queue_item(1'b1, HDR_W'((raw_count - 1) & 'h7F), '0, '0);
      for (int unsigned i = 0; i < raw_count; i += SLOTS) begin
         n = (raw_count - i > SLOTS) ? SLOTS : raw_count - i;
         for (int unsigned k = 0; k < SLOTS; k++)
            group[k] = (i + k < raw_count) ? raw_pixels[i + k] : '0;
         queue_item(1'b0, '0, PCNT_W'(n), group);
      end
      raw_count = 0;
   endfunction

   function automatic void emit_run_packet(input int unsigned len);
      queue_item(1'b1, 8'h80 | HDR_W'((len - 1) & 'h7F), '0, '0);
      queue_item(1'b0, '0, PCNT_W'(1), {{(SLOTS - 1){32'h0}}, cand_pixel});
   endfunction

   function automatic void hold_raw(input logic [PIX_W-1:0] p);
      if (raw_count < PACKET_MAX) begin
         raw_pixels[raw_count] = p;
         raw_count++;
      end
   endfunction

   // Works out every result item caused by one accepted pixel.
   function automatic void encode_pixel(input logic [PIX_W-1:0] x);
      bit          same;
      int unsigned first;
      first = packets_due.size();
      same  = (cand_len != 0) && (visible(x ^ cand_pixel) == '0);
      if (cand_len == 0) begin
         cand_pixel = x;
         cand_len   = 1;
      end else if (cand_len == 1) begin
         if (same) begin
            flush_raw_packet();
            cand_len = 2;
         end else begin
            hold_raw(cand_pixel);
            if (raw_count >= PACKET_MAX)
               flush_raw_packet();
            cand_pixel = x;
            cand_len   = 1;
         end
      end else begin
         if (same && cand_len < PACKET_MAX) begin
            cand_len++;
         end else begin
            emit_run_packet(cand_len);
            cand_pixel = x;
            cand_len   = 1;
         end
      end
      if (int'(col_pos) + 1 >= int'(cfg_width)) begin
         if (cand_len >= 2) begin
            flush_raw_packet();
            emit_run_packet(cand_len);
         end else if (cand_len == 1) begin
            hold_raw(cand_pixel);
            flush_raw_packet();
         end
         cand_len = 0;
         col_pos  = '0;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      if (packets_due.size() > first)
         packets_due[packets_due.size() - 1].end_of_burst = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                  input logic [PIX_W-1:0] want);
      $display("mismatch at result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [PIX_W-1:0] got,
                              input logic [PIX_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rle_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (packets_due.size() == 0) begin
            report_mismatch("no result pending", rsp_header_byte, '0);
         end else begin
            want = packets_due.pop_front();
            check_field("is_header", rsp_is_header, want.is_header);
            check_field("header_byte", rsp_header_byte, want.header_byte);
            check_field("pixel_count", rsp_pixel_count, want.pixel_count);
            check_field("pixel_a", rsp_pixel_a, want.slot[0]);
            check_field("pixel_b", rsp_pixel_b, want.slot[1]);
            check_field("pixel_c", rsp_pixel_c, want.slot[2]);
            check_field("pixel_d", rsp_pixel_d, want.slot[3]);
            check_field("end_of_burst", rsp_end_of_burst, want.end_of_burst);
         end
      end
      rsp_pop <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic send_pixel(input logic [PIX_W-1:0] x);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_pixel_word <= x;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      encode_pixel(x);
      last_word = x;
   endtask

   task automatic send_run(input logic [PIX_W-1:0] p, input int unsigned len);
      logic [PIX_W-1:0] w;
      for (int unsigned i = 0; i < len; i++) begin
         w = p;
         // Without alpha the top byte must not break the run.
         if (!cfg_alpha && $urandom_range(1))
            w[31:24] = 8'($urandom);
         send_pixel(w);
      end
   endtask

   task automatic send_raw(input int unsigned len);
      logic [PIX_W-1:0] w;
      for (int unsigned i = 0; i < len; i++) begin
         w = $urandom;
         if (visible(w ^ last_word) == '0)
            w[0] = ~w[0];
         send_pixel(w);
      end
   endtask

   task automatic wait_until_idle();
      req_push <= 1'b0;
      while (packets_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_encoder(input logic alpha, input logic [COL_W-1:0] width,
                                  input bit with_unused);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      for (int k = 0; k < 3; k++) begin
         if (k < 2 || with_unused) begin
            case (k)
               0: begin
                  idx  = CSR_HAS_ALPHA;
                  data = {15'($urandom), alpha};
               end
               1: begin
                  idx  = CSR_ROW_WIDTH;
                  data = width;
               end
               default: begin
                  idx  = CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1,
                                                   int'(CSR_ROW_WIDTH) + 1));
                  data = CSR_DATA_W'($urandom);
               end
            endcase
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_wdata <= data;
            @(posedge clock);
            while (!csr_ready)
               @(posedge clock);
            if (idx == CSR_HAS_ALPHA)
               cfg_alpha = data[0];
            else if (idx == CSR_ROW_WIDTH)
               cfg_width = data;
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_rows();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hA5A5_5A5A);
   endtask

   task automatic test_runs_and_raws();
      wait_until_idle();
      program_encoder(1'b1, 16'd6, 1'b0);
      send_run(32'h1122_3344, 3);
      send_pixel(32'h0000_0001);
      send_pixel(32'h0000_0002);
      send_pixel(32'h0000_0003);
      send_pixel(32'h0000_0001);
      send_run(32'h0000_0002, 2);
      send_pixel(32'h0000_0003);
      send_run(32'h8000_0000, 2);
   endtask

   task automatic test_alpha_ignored();
      wait_until_idle();
      program_encoder(1'b0, 16'd4, 1'b1);
      send_pixel(32'h1122_3344);
      send_pixel(32'hEE22_3344);
      send_pixel(32'hFF00_0000);
      send_pixel(32'h00FF_FFFF);
   endtask

   task automatic test_row_width_edges();
      wait_until_idle();
      program_encoder(1'b1, 16'd0, 1'b0);
      send_run(32'h7777_7777, 2);
      wait_until_idle();
      program_encoder(1'b1, 16'd3, 1'b0);
      send_pixel(32'h0101_0101);
      send_pixel(32'h0202_0202);
      // Narrowing the row mid-row ends it on the next pixel.
      wait_until_idle();
      program_encoder(1'b1, 16'd2, 1'b0);
      send_pixel(32'h0303_0303);
   endtask

   task automatic test_full_packets();
      wait_until_idle();
      program_encoder(1'b1, 16'hFFFF, 1'b1);
      quiet = 1'b1;
      send_run($urandom, PACKET_MAX + 2);
      send_raw(PACKET_MAX + 3);
      wait_until_idle();
      quiet = 1'b0;
   endtask

   task automatic random_phase(input logic alpha, input logic [COL_W-1:0] width,
                               input int unsigned items);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      wait_until_idle();
      program_encoder(alpha, width, 1'b1);
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = $urandom_range(6, 2);
            send_run($urandom, len);
         end else if (pick < 85) begin
            len = $urandom_range(5, 1);
            send_raw(len);
         end else begin
            len = 1;
            send_pixel({8'($urandom_range(1)), 22'h0, 2'($urandom_range(3))});
         end
         sent += len;
      end
   endtask

   task automatic test_random_traffic();
      random_phase(1'b0, 16'd5, 15);
      random_phase(1'b1, 16'd13, 20);
      random_phase(1'b0, 16'd1, 8);
      random_phase(1'b1, 16'd0, 8);
      random_phase(1'($urandom_range(1)), COL_W'($urandom_range(40, 2)), 25);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_rows();
      test_runs_and_raws();
      test_alpha_ignored();
      test_row_width_edges();
      test_full_packets();
      test_random_traffic();
      wait_until_idle();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### tga_rle_packet_encoder.f
hw/rtl/tre_pkg.sv
hw/rtl/tre_cmd_queue.sv
hw/rtl/tre_front.sv
hw/rtl/tre_back.sv
hw/rtl/tga_rle_packet_encoder.sv
bench/testbench.sv
